[rtl/core/ipf_pkg.sv]
// Shared types, codes and helpers for the IPv4 allow/deny prefix filter.
// No dependencies; imported by ipf_table, ipv4_allow_deny_prefix_filter and the testbench.
package ipf_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned PrefixW = 6;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned CodeW   = 3;

  localparam logic [PrefixW-1:0] PrefixMax = PrefixW'(AddrW);
  localparam logic [AddrW-1:0]   AllOnes   = {AddrW{1'b1}};

  typedef enum logic [1:0] {
    CMD_CHECK    = 2'd0,
    CMD_WR_ALLOW = 2'd1,
    CMD_WR_DENY  = 2'd2
  } ipf_cmd_e;

  typedef enum logic [CodeW-1:0] {
    DEC_DENY_ALL    = 3'd0,
    DEC_DENY_MATCH  = 3'd1,
    DEC_ALLOW_ALL   = 3'd2,
    DEC_ALLOW_MATCH = 3'd3,
    DEC_NO_MATCH    = 3'd4,
    DEC_WRITE_DONE  = 3'd5
  } ipf_dec_e;

  // One table write beat, prefix already saturated to 32.
  typedef struct packed {
    logic                 en;
    logic [IndexW-1:0]    index;
    logic [AddrW-1:0]     network;
    logic [PrefixW-1:0]   prefix;
    logic                 valid;
  } ipf_wr_t;

  // Length 0 matches everything; lengths of 32 and above are a full mask.
  function automatic logic [AddrW-1:0] prefix_mask(input logic [PrefixW-1:0] len);
    logic [AddrW-1:0] m;
    if (len == '0) begin
      m = '0;
    end else if (len >= PrefixMax) begin
      m = AllOnes;
    end else begin
      m = AllOnes << (PrefixMax - len);
    end
    return m;
  endfunction

endpackage

[rtl/core/ipf_table.sv]
// One prefix table: entry registers, per-slot write decode and parallel match.
// Depends on ipf_pkg.
module ipf_table import ipf_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ipf_wr_t          wr_i,
  input  logic [AddrW-1:0] lookup_addr_i,
  output logic             hit_o
);

  // Entries keep the network pre-masked together with the mask.
  logic [AddrW-1:0] net_q  [ENTRIES];
  logic [AddrW-1:0] mask_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] match;

  logic [AddrW-1:0] wr_mask;
  logic [8:0]       wr_slot;

  assign wr_mask = prefix_mask(wr_i.prefix);
  assign wr_slot = {{(9-IndexW){1'b0}}, wr_i.index};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_entry
    logic sel;
    assign sel = wr_i.en && (wr_slot == 9'(i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (sel) begin
        valid_q[i] <= wr_i.valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (sel) begin
        net_q[i]  <= wr_i.network & wr_mask;
        mask_q[i] <= wr_mask;
      end
    end

    assign match[i] = valid_q[i] && ((lookup_addr_i & mask_q[i]) == net_q[i]);
  end

  assign hit_o = |match;

endmodule

[rtl/core/ipv4_allow_deny_prefix_filter.sv]
// Top level of the IPv4 allow/deny prefix filter: input register, two
// prefix tables, decision logic and result register. Depends on ipf_pkg, ipf_table.

// Usage: a beat is taken on every clock edge with start_i high; busy_o is
// always low, so one check or table write enters per cycle and results
// come out at the same rate. Each beat gives exactly one result on
// done_o/allowed_o/decision_code_o, by way of the input register, then all
// table entries compared in parallel into the result register. The
// receiver cannot stall: a result is present for exactly one
// cycle. A table write takes effect for the very next beat. Write beats
// and unused commands return allowed = 0 with the write-done code. Tables
// come out of reset with every entry invalid; allow_all resets to 1 and
// deny_all to 0, and both should only be written while no beat is in flight.
module ipv4_allow_deny_prefix_filter import ipf_pkg::*; #(
  parameter int unsigned ALLOW_ENTRIES = 16,
  parameter int unsigned DENY_ENTRIES  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         command_i,
  input  logic [IndexW-1:0]  entry_index_i,
  input  logic [AddrW-1:0]   address_i,
  input  logic [PrefixW-1:0] prefix_len_i,
  input  logic               entry_valid_i,
  // result channel
  output logic               done_o,
  output logic               allowed_o,
  output logic [CodeW-1:0]   decision_code_o,
  // configuration: index 0 allow_all, index 1 deny_all
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic               cfg_wdata_i
);

  localparam logic CfgAllowAll = 1'b0;
  localparam logic CfgDenyAll  = 1'b1;

  // ---------------- configuration registers ----------------
  logic allow_all_q;
  logic deny_all_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_all_q <= 1'b1;
      deny_all_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgAllowAll: allow_all_q <= cfg_wdata_i;
        CfgDenyAll:  deny_all_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Never stalls: every cycle can take a beat.
  assign busy_o = 1'b0;

  // ---------------- input register ----------------
  logic               in_vld_q;
  logic [1:0]         cmd_q;
  logic [IndexW-1:0]  idx_q;
  logic [AddrW-1:0]   addr_q;
  logic [PrefixW-1:0] plen_q;
  logic               ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cmd_q  <= command_i;
      idx_q  <= entry_index_i;
      addr_q <= address_i;
      plen_q <= prefix_len_i;
      ev_q   <= entry_valid_i;
    end
  end

  // ---------------- table writes ----------------
  // Out-of-range slots simply decode to no entry inside the table.
  logic [PrefixW-1:0] plen_sat;
  ipf_wr_t            allow_wr;
  ipf_wr_t            deny_wr;

  assign plen_sat = (plen_q > PrefixMax) ? PrefixMax : plen_q;

  always_comb begin
    allow_wr.en      = in_vld_q && (cmd_q == CMD_WR_ALLOW);
    allow_wr.index   = idx_q;
    allow_wr.network = addr_q;
    allow_wr.prefix  = plen_sat;
    allow_wr.valid   = ev_q;
    deny_wr          = allow_wr;
    deny_wr.en       = in_vld_q && (cmd_q == CMD_WR_DENY);
  end

  // ---------------- lookup ----------------
  logic allow_hit;
  logic deny_hit;

  ipf_table #(.ENTRIES(ALLOW_ENTRIES)) u_allow (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (allow_wr),
    .lookup_addr_i (addr_q),
    .hit_o         (allow_hit)
  );

  ipf_table #(.ENTRIES(DENY_ENTRIES)) u_deny (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (deny_wr),
    .lookup_addr_i (addr_q),
    .hit_o         (deny_hit)
  );

  // ---------------- decision ----------------
  // Priority: deny-all, deny match, allow-all, allow match, default deny.
  logic     allowed_d;
  ipf_dec_e code_d;

  always_comb begin
    allowed_d = 1'b0;
    code_d    = DEC_WRITE_DONE;
    if (cmd_q == CMD_CHECK) begin
      if (deny_all_q) begin
        code_d = DEC_DENY_ALL;
      end else if (deny_hit) begin
        code_d = DEC_DENY_MATCH;
      end else if (allow_all_q) begin
        allowed_d = 1'b1;
        code_d    = DEC_ALLOW_ALL;
      end else if (allow_hit) begin
        allowed_d = 1'b1;
        code_d    = DEC_ALLOW_MATCH;
      end else begin
        code_d = DEC_NO_MATCH;
      end
    end
  end

  // ---------------- result register ----------------
  logic           done_q;
  logic           allowed_q;
  logic [CodeW-1:0] code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      allowed_q <= allowed_d;
      code_q    <= code_d;
    end
  end

  assign done_o          = done_q;
  assign allowed_o       = allowed_q;
  assign decision_code_o = code_q;

endmodule

[tb/tb_ipv4_allow_deny_prefix_filter.sv]
// Self-checking testbench for ipv4_allow_deny_prefix_filter: directed and random beats
// are checked against a behavioral filter kept in a scoreboard class.
// Depends on ipf_pkg and the filter RTL.
module tb_ipv4_allow_deny_prefix_filter;
  import ipf_pkg::*;

  localparam int unsigned TableDepth = 16;
  localparam logic [1:0]  CmdUnused  = 2'd3;   // no command behind this code
  localparam logic        CfgAllowAll = 1'b0;
  localparam logic        CfgDenyAll  = 1'b1;
  localparam int unsigned PhaseBeats  = 105;
  localparam int unsigned NumPhases   = 7;

  // What one result beat should carry.
  typedef struct packed {
    logic     allowed;
    ipf_dec_e code;
  } verdict_t;

  // Behavioral copy of both tables plus the two policy bits, and the queue of
  // verdicts still owed by the block.
  class filter_scoreboard;
    logic [AddrW-1:0]   allow_net [TableDepth];
    logic [PrefixW-1:0] allow_len [TableDepth];
    bit                 allow_ok  [TableDepth];
    logic [AddrW-1:0]   deny_net  [TableDepth];
    logic [PrefixW-1:0] deny_len  [TableDepth];
    bit                 deny_ok   [TableDepth];
    bit                 allow_all;
    bit                 deny_all;
    verdict_t           verdict_q[$];
    int                 errors;

    function new();
      for (int i = 0; i < TableDepth; i++) begin
        allow_net[i] = '0;
        allow_len[i] = '0;
        allow_ok[i]  = 1'b0;
        deny_net[i]  = '0;
        deny_len[i]  = '0;
        deny_ok[i]   = 1'b0;
      end
      allow_all = 1'b1;
      deny_all  = 1'b0;
      errors    = 0;
    endfunction

    // Length 0 gives an empty mask; 32 shifts every one out, giving a full mask.
    function logic [AddrW-1:0] net_mask(logic [PrefixW-1:0] len);
      logic [AddrW-1:0] ones;
      ones = '1;
      return ~(ones >> len);
    endfunction

    function bit covers(bit deny_side, logic [AddrW-1:0] addr);
      logic [AddrW-1:0] m;
      for (int i = 0; i < TableDepth; i++) begin
        if (deny_side ? deny_ok[i] : allow_ok[i]) begin
          m = net_mask(deny_side ? deny_len[i] : allow_len[i]);
          if ((addr & m) == ((deny_side ? deny_net[i] : allow_net[i]) & m)) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_config(logic idx, logic val);
      if (idx == CfgAllowAll) allow_all = val;
      else deny_all = val;
    endfunction

    function void note_beat(logic [1:0] cmd, logic [IndexW-1:0] idx,
                            logic [AddrW-1:0] addr, logic [PrefixW-1:0] len,
                            logic valid);
      verdict_t v;
      logic [PrefixW-1:0] sat;
      sat = (len > PrefixMax) ? PrefixMax : len;
      v.allowed = 1'b0;
      v.code    = DEC_WRITE_DONE;
      if (cmd == CMD_CHECK) begin
        if (deny_all) begin
          v.code = DEC_DENY_ALL;
        end else if (covers(1'b1, addr)) begin
          v.code = DEC_DENY_MATCH;
        end else if (allow_all) begin
          v.allowed = 1'b1;
          v.code    = DEC_ALLOW_ALL;
        end else if (covers(1'b0, addr)) begin
          v.allowed = 1'b1;
          v.code    = DEC_ALLOW_MATCH;
        end else begin
          v.code = DEC_NO_MATCH;
        end
      end else if (cmd == CMD_WR_ALLOW && idx < TableDepth) begin
        allow_net[idx] = addr;
        allow_len[idx] = sat;
        allow_ok[idx]  = valid;
      end else if (cmd == CMD_WR_DENY && idx < TableDepth) begin
        deny_net[idx] = addr;
        deny_len[idx] = sat;
        deny_ok[idx]  = valid;
      end
      verdict_q = {verdict_q, v};
    endfunction

    function void check_verdict(logic allowed, logic [CodeW-1:0] code);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $error("result beat with nothing outstanding: allowed %0d code %0d", allowed, code);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (allowed !== v.allowed) begin
        $error("allowed: expected %0d, got %0d", v.allowed, allowed);
        errors++;
      end
      if (code !== v.code) begin
        $error("decision_code: expected %0d, got %0d", v.code, code);
        errors++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         command_i = '0;
  logic [IndexW-1:0]  entry_index_i = '0;
  logic [AddrW-1:0]   address_i = '0;
  logic [PrefixW-1:0] prefix_len_i = '0;
  logic               entry_valid_i = 1'b0;
  logic               done_o;
  logic               allowed_o;
  logic [CodeW-1:0]   decision_code_o;
  logic               cfg_we_i = 1'b0;
  logic               cfg_index_i = 1'b0;
  logic               cfg_wdata_i = 1'b0;

  filter_scoreboard sb = new();

  // Network pool: recent entry addresses, so random checks land on entries.
  logic [AddrW-1:0] net_pool [TableDepth];
  bit               gaps_on;

  always #2 clk_i = ~clk_i;

  ipv4_allow_deny_prefix_filter u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .entry_index_i  (entry_index_i),
    .address_i      (address_i),
    .prefix_len_i   (prefix_len_i),
    .entry_valid_i  (entry_valid_i),
    .done_o         (done_o),
    .allowed_o      (allowed_o),
    .decision_code_o(decision_code_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Monitor: every sample is taken at the edge, before the edge's updates land.
  // Config writes, accepted command beats and result beats all go to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.note_config(cfg_index_i, cfg_wdata_i);
      if (start_i && !busy_o) begin
        sb.note_beat(command_i, entry_index_i, address_i, prefix_len_i, entry_valid_i);
      end
      if (done_o) sb.check_verdict(allowed_o, decision_code_o);
    end
  end

  // Mostly back-to-back, sometimes a short gap, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // Drive one command beat, hold it until taken, then maybe idle a while.
  // Called at a rising edge; returns at a rising edge.
  task automatic send_beat(input logic [1:0] cmd, input logic [IndexW-1:0] idx,
                           input logic [AddrW-1:0] addr, input logic [PrefixW-1:0] len,
                           input logic valid);
    int unsigned gap;
    command_i     <= cmd;
    entry_index_i <= idx;
    address_i     <= addr;
    prefix_len_i  <= len;
    entry_valid_i <= valid;
    start_i       <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every owed result, plus the two-stage pipe.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random beat: about half checks, the rest table writes and a few
  // unused-command beats. Checks often target a pooled network.
  task automatic random_beat();
    int unsigned        r;
    logic [1:0]         cmd;
    logic [AddrW-1:0]   addr;
    logic [PrefixW-1:0] len;
    logic               valid;
    logic [IndexW-1:0]  idx;
    r    = $urandom_range(0, 19);
    idx  = IndexW'($urandom_range(0, TableDepth - 1));
    addr = ($urandom_range(0, 1) == 1) ? $urandom()
         : net_pool[$urandom_range(0, TableDepth - 1)] ^ ($urandom() >> $urandom_range(0, 32));
    len   = PrefixW'($urandom_range(0, 63));
    valid = $urandom_range(0, 3) != 0;
    if (r < 10) begin
      cmd = CMD_CHECK;
    end else if (r == 19) begin
      cmd = CmdUnused;
    end else begin
      cmd = (r < 15) ? CMD_WR_ALLOW : CMD_WR_DENY;
      r = $urandom_range(0, 19);
      // Short deny prefixes would swallow most checks, so keep them rare.
      if (r == 0) len = '0;
      else if (r == 1) len = PrefixW'($urandom_range(33, 63));
      else if (cmd == CMD_WR_DENY) len = PrefixW'($urandom_range(8, 32));
      else len = PrefixW'($urandom_range(1, 32));
      net_pool[$urandom_range(0, TableDepth - 1)] = addr;
    end
    send_beat(cmd, idx, addr, len, valid);
  endtask

  initial begin
    for (int i = 0; i < TableDepth; i++) net_pool[i] = $urandom();
    gaps_on = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset policy is allow-all, no deny-all.
    send_beat(CMD_CHECK,    4'd0,  32'h0000_0000, 6'd0,  1'b0);
    send_beat(CMD_CHECK,    4'd15, 32'hFFFF_FFFF, 6'd63, 1'b1);
    send_beat(CMD_WR_DENY,  4'd0,  32'h0A00_0000, 6'd8,  1'b1);
    send_beat(CMD_CHECK,    4'd0,  32'h0A01_0203, 6'd0,  1'b0);
    send_beat(CMD_CHECK,    4'd0,  32'h0B00_0000, 6'd0,  1'b0);
    // prefix above 32 must behave as an exact host entry
    send_beat(CMD_WR_DENY,  4'd15, 32'hC0A8_0101, 6'd63, 1'b1);
    send_beat(CMD_CHECK,    4'd0,  32'hC0A8_0101, 6'd0,  1'b0);
    send_beat(CMD_CHECK,    4'd0,  32'hC0A8_0100, 6'd0,  1'b0);
    send_beat(CmdUnused,    4'd4,  32'hDEAD_BEEF, 6'd17, 1'b1);
    // invalid catch-all entry, then a /12 allow entry
    send_beat(CMD_WR_ALLOW, 4'd3,  32'h1234_5678, 6'd0,  1'b0);
    send_beat(CMD_WR_ALLOW, 4'd5,  32'hAC10_0000, 6'd12, 1'b1);
    drain();
    write_cfg(CfgAllowAll, 1'b0);
    send_beat(CMD_CHECK,    4'd0,  32'hAC1F_0001, 6'd0,  1'b0);
    send_beat(CMD_CHECK,    4'd0,  32'h0808_0808, 6'd0,  1'b0);
    send_beat(CMD_WR_ALLOW, 4'd3,  32'h0000_0000, 6'd0,  1'b1);
    send_beat(CMD_CHECK,    4'd0,  32'h0808_0808, 6'd0,  1'b0);
    send_beat(CMD_WR_DENY,  4'd7,  32'hFFFF_FFFF, 6'd32, 1'b0);
    send_beat(CMD_CHECK,    4'd0,  32'hFFFF_FFFF, 6'd0,  1'b0);
    // a valid /0 deny entry shuts everything out until removed
    send_beat(CMD_WR_DENY,  4'd8,  32'h0000_0000, 6'd0,  1'b1);
    send_beat(CMD_CHECK,    4'd0,  32'h0102_0304, 6'd0,  1'b0);
    send_beat(CMD_WR_DENY,  4'd8,  32'h0000_0000, 6'd0,  1'b0);
    send_beat(CMD_CHECK,    4'd0,  32'h0102_0304, 6'd0,  1'b0);
    drain();
    write_cfg(CfgDenyAll, 1'b1);
    send_beat(CMD_CHECK,    4'd0,  32'h0808_0808, 6'd0,  1'b0);
    send_beat(CMD_WR_ALLOW, 4'd0,  32'hFFFF_FFFF, 6'd32, 1'b1);
    send_beat(CMD_CHECK,    4'd0,  32'hFFFF_FFFF, 6'd0,  1'b0);

    // Random phases walk all four policy settings; some run without gaps.
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_cfg(CfgAllowAll, p[0]);
      write_cfg(CfgDenyAll, p[1]);
      gaps_on = (p % 3) != 2;
      for (int n = 0; n < PhaseBeats; n++) random_beat();
    end

    drain();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #800000;
    $display("simulation failed");
    $finish;
  end

endmodule
